// ===== design/sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types, constants and the CRC-8 byte update for the frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int BYTE_W    = 8;
  localparam int HDR_LEN   = 5;
  localparam int HDR_IDX_W = 3;
  localparam int LEN_W     = 6;
  localparam int POS_W     = 5;
  localparam int CFG_IDX_W = 3;

  // Header byte slots
  localparam int HDR_SOURCE = 0;
  localparam int HDR_TARGET = 1;
  localparam int HDR_CMD    = 2;
  localparam int HDR_SEQ    = 3;
  localparam int HDR_LENGTH = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_ONE = 3'd0,
    CFG_START_TWO = 3'd1,
    CFG_POLY      = 3'd2,
    CFG_INIT      = 3'd3,
    CFG_FINAL_XOR = 3'd4
  } cfg_reg_t;

  localparam logic [BYTE_W-1:0] RST_START_ONE = 8'hAA;
  localparam logic [BYTE_W-1:0] RST_START_TWO = 8'h55;
  localparam logic [BYTE_W-1:0] RST_POLY      = 8'h07;
  localparam logic [BYTE_W-1:0] RST_INIT      = 8'h00;
  localparam logic [BYTE_W-1:0] RST_FINAL_XOR = 8'h00;

  typedef enum logic [2:0] {
    ST_SYNC1,
    ST_SYNC2,
    ST_HEADER,
    ST_PAYLOAD,
    ST_CRC,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic start_frame;  // clear header and payload counts, load CRC initial value
    logic hdr_wr;       // store header byte, update CRC
    logic pay_wr;       // store payload byte, update CRC
    logic emit_clr;     // rewind result index
    logic emit_next;    // advance result index
    logic load_out;     // load output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_start_one;
    logic is_start_two;
    logic hdr_last;
    logic len_bad;
    logic len_zero;
    logic pay_last;
    logic crc_ok;
    logic emit_last;
    logic out_free;
  } status_t;

  function automatic logic [BYTE_W-1:0] crc8_step(
    input logic [BYTE_W-1:0] crc,
    input logic [BYTE_W-1:0] data,
    input logic [BYTE_W-1:0] poly
  );
    logic [BYTE_W-1:0] v;
    v = crc ^ data;
    for (int i = 0; i < BYTE_W; i++) begin
      if (v[BYTE_W-1]) begin
        v = {v[BYTE_W-2:0], 1'b0} ^ poly;
      end else begin
        v = {v[BYTE_W-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ===== design/sfp_in_if.sv =====
// ----------------------------------------------------------------------------
// sfp_in_if
// Received byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface sfp_in_if;
  import sfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/sfp_out_if.sv =====
// ----------------------------------------------------------------------------
// sfp_out_if
// Result channel: one item per payload byte of a verified frame, or one for a zero-length frame.
// ----------------------------------------------------------------------------
interface sfp_out_if;
  import sfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] source_id;
  logic [BYTE_W-1:0] target_id;
  logic [BYTE_W-1:0] command;
  logic [BYTE_W-1:0] sequence_res;
  logic [LEN_W-1:0]  payload_length;
  logic [POS_W-1:0]  byte_position;
  logic [BYTE_W-1:0] payload_byte;
  logic              last_of_frame;

  modport source (
    output valid, input ready,
    output source_id, output target_id, output command, output sequence_res,
    output payload_length, output byte_position, output payload_byte,
    output last_of_frame
  );
  modport sink (
    input valid, output ready,
    input source_id, input target_id, input command, input sequence_res,
    input payload_length, input byte_position, input payload_byte,
    input last_of_frame
  );
endinterface

// ===== design/sof_frame_parser_crc8.sv =====
// ----------------------------------------------------------------------------
// sof_frame_parser_crc8
// Start-of-frame packet receiver with CRC-8 check, byte in, results out.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one received byte per item (valid/ready). Sync bytes, header,
//         payload and the CRC byte all arrive on this channel.
//   res : one item per payload byte of a frame whose CRC matches, or a
//         single item for a zero-length frame; last_of_frame marks the end.
//   cfg : cfg_we/cfg_index/cfg_data write the sync bytes, polynomial, CRC
//         initial value and final xor; write only while the block is idle.
// Sequence: after the CRC byte is taken, the run steps through ST_EMIT_RD,
//   the registered read of the payload store, and ST_EMIT_LD, the output
//   load, which waits for a free output register; each result repeats both.
// rx.ready is low for the whole result run and high otherwise; a stalled
//   res holds its item, and the run waits for it. The last result may
//   still wait in the output register while new bytes are taken.
// Reset returns the parser to the sync hunt, loads the default register
//   values and empties the output register. The payload store needs no
//   clearing pass.
// ----------------------------------------------------------------------------
module sof_frame_parser_crc8 #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfp_pkg::BYTE_W-1:0]    cfg_data,
  sfp_in_if.sink                        rx,
  sfp_out_if.source                     res
);
  import sfp_pkg::*;

  cmd_t    cmd;
  status_t status;

  sfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sfp_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (rx.rx_byte),
    .cmd       (cmd),
    .status    (status),
    .res       (res)
  );

endmodule

// ===== design/sfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfp_ctrl
// Parse state machine: sync hunt, header, payload, CRC check, result run.
// ----------------------------------------------------------------------------
module sfp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfp_pkg::status_t status,
  output sfp_pkg::cmd_t    cmd
);
  import sfp_pkg::*;

  state_t state;
  state_t state_next;
  logic   fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SYNC1;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state != ST_EMIT_RD) && (state != ST_EMIT_LD);
  assign fire     = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_SYNC1: begin
        if (fire && status.is_start_one) begin
          state_next = ST_SYNC2;
        end
      end
      ST_SYNC2: begin
        if (fire) begin
          if (status.is_start_two) begin
            cmd.start_frame = 1'b1;
            state_next      = ST_HEADER;
          end else if (!status.is_start_one) begin
            state_next = ST_SYNC1;
          end
        end
      end
      ST_HEADER: begin
        if (fire) begin
          cmd.hdr_wr = 1'b1;
          if (status.hdr_last) begin
            if (status.len_bad) begin
              state_next = ST_SYNC1;
            end else if (status.len_zero) begin
              state_next = ST_CRC;
            end else begin
              state_next = ST_PAYLOAD;
            end
          end
        end
      end
      ST_PAYLOAD: begin
        if (fire) begin
          cmd.pay_wr = 1'b1;
          if (status.pay_last) begin
            state_next = ST_CRC;
          end
        end
      end
      ST_CRC: begin
        if (fire) begin
          if (status.crc_ok) begin
            cmd.emit_clr = 1'b1;
            state_next   = ST_EMIT_RD;
          end else begin
            state_next = ST_SYNC1;
          end
        end
      end
      ST_EMIT_RD: begin
        // payload store read is in flight
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (status.emit_last) begin
            state_next = ST_SYNC1;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_SYNC1;
      end
    endcase
  end

endmodule

// ===== design/sfp_datapath.sv =====
// ----------------------------------------------------------------------------
// sfp_datapath
// Config registers, header and payload storage, CRC-8 and output register.
// ----------------------------------------------------------------------------
module sfp_datapath #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sfp_pkg::BYTE_W-1:0]           cfg_data,
  input  logic [sfp_pkg::BYTE_W-1:0]           rx_byte,
  input  sfp_pkg::cmd_t                        cmd,
  output sfp_pkg::status_t                     status,
  sfp_out_if.source                            res
);
  import sfp_pkg::*;

  localparam int PCW = $clog2(MAX_PAYLOAD + 1);
  localparam int IW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

  logic [BYTE_W-1:0]    start_one;
  logic [BYTE_W-1:0]    start_two;
  logic [BYTE_W-1:0]    poly;
  logic [BYTE_W-1:0]    crc_init;
  logic [BYTE_W-1:0]    final_xor;

  logic [BYTE_W-1:0]    header_bytes [HDR_LEN];
  logic [HDR_IDX_W-1:0] header_count;
  logic [PCW-1:0]       payload_count;
  logic [IW-1:0]        emit_idx;
  logic [BYTE_W-1:0]    running_crc;
  logic [BYTE_W-1:0]    crc_next;
  logic [BYTE_W-1:0]    payload_store [MAX_PAYLOAD];
  logic [BYTE_W-1:0]    rd_data;
  logic [BYTE_W-1:0]    hdr_len;
  logic [BYTE_W-1:0]    emit_pos;
  logic                 out_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_one <= RST_START_ONE;
      start_two <= RST_START_TWO;
      poly      <= RST_POLY;
      crc_init  <= RST_INIT;
      final_xor <= RST_FINAL_XOR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_ONE: start_one <= cfg_data;
        CFG_START_TWO: start_two <= cfg_data;
        CFG_POLY:      poly      <= cfg_data;
        CFG_INIT:      crc_init  <= cfg_data;
        CFG_FINAL_XOR: final_xor <= cfg_data;
        default: ;
      endcase
    end
  end

  assign crc_next  = crc8_step(running_crc, rx_byte, poly);
  assign hdr_len   = header_bytes[HDR_LENGTH];
  assign emit_pos  = BYTE_W'(emit_idx);

  // Counters and CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count  <= '0;
      payload_count <= '0;
      emit_idx      <= '0;
      running_crc   <= RST_INIT;
    end else begin
      if (cmd.start_frame) begin
        header_count  <= '0;
        payload_count <= '0;
        running_crc   <= crc_init;
      end
      if (cmd.hdr_wr) begin
        header_count <= header_count + 1'b1;
        running_crc  <= crc_next;
      end
      if (cmd.pay_wr) begin
        payload_count <= payload_count + 1'b1;
        running_crc   <= crc_next;
      end
      if (cmd.emit_clr) begin
        emit_idx <= '0;
      end else if (cmd.emit_next) begin
        emit_idx <= emit_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_wr) begin
      header_bytes[header_count] <= rx_byte;
    end
  end

  // Payload store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.pay_wr) begin
      payload_store[payload_count[IW-1:0]] <= rx_byte;
    end
    rd_data <= payload_store[emit_idx];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res.source_id      <= header_bytes[HDR_SOURCE];
      res.target_id      <= header_bytes[HDR_TARGET];
      res.command        <= header_bytes[HDR_CMD];
      res.sequence_res   <= header_bytes[HDR_SEQ];
      res.payload_length <= hdr_len[LEN_W-1:0];
      res.byte_position  <= emit_pos[POS_W-1:0];
      res.payload_byte   <= (hdr_len == '0) ? '0 : rd_data;
      res.last_of_frame  <= status.emit_last;
    end
  end

  assign res.valid = out_valid;

  always_comb begin
    status.is_start_one = (rx_byte == start_one);
    status.is_start_two = (rx_byte == start_two);
    status.hdr_last     = (header_count == HDR_IDX_W'(HDR_LEN - 1));
    status.len_bad      = (rx_byte > MAX_LEN);
    status.len_zero     = (rx_byte == '0);
    status.pay_last     = ((BYTE_W'(payload_count) + 1'b1) == hdr_len);
    status.crc_ok       = ((running_crc ^ final_xor) == rx_byte);
    status.emit_last    = (hdr_len == '0) || ((emit_pos + 1'b1) == hdr_len);
    status.out_free     = !out_valid || res.ready;
  end

endmodule

// ===== design/sfp_checker.sv =====
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks on the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module sfp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_payload_byte,
  input logic [4:0] out_byte_position,
  input logic       out_last
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_byte_position) && $stable(out_last))
    else $error("stalled result changed");

  // Intake stays paused while a run is still incomplete
  a_run_pause: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("byte taken in the middle of a result run");

  // A taken byte never makes a result appear in the next cycle
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after a byte");

  // Reset empties the output and opens intake
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind sof_frame_parser_crc8 sfp_checker u_sfp_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (rx.valid),
  .in_ready          (rx.ready),
  .out_valid         (res.valid),
  .out_ready         (res.ready),
  .out_payload_byte  (res.payload_byte),
  .out_byte_position (res.byte_position),
  .out_last          (res.last_of_frame)
);
